[hdl/tlb_pkg.sv]
// Shared types and constants for the TLB address translation block.
`default_nettype none
package tlb_pkg;

    localparam int VA_W          = 32;
    localparam int WORD_W        = 32;
    localparam int IDX_W         = 5;
    localparam int ASID_W        = 8;
    localparam int PFN_W         = 20;
    localparam int OFFSET_W      = 12;
    localparam int PAGE_PAIR_LSB = 13;
    localparam int ODD_PAGE_BIT  = 12;
    localparam int PFN_LSB       = 6;
    localparam int PFN_MSB       = 25;
    localparam int LO_G          = 0;
    localparam int LO_V          = 1;
    localparam int LO_D          = 2;

    localparam logic OP_TRANSLATE = 1'b0;
    localparam logic OP_WRITE     = 1'b1;

    localparam int   APB_ADDR_W       = 1;
    localparam int   APB_DATA_W       = 32;
    localparam logic ADDR_CURRENT_ASID = 1'b0;

    typedef enum logic [1:0] {
        FAULT_NONE     = 2'd0,
        FAULT_REFILL   = 2'd1,
        FAULT_INVALID  = 2'd2,
        FAULT_MODIFIED = 2'd3
    } t_fault;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_HOLD
    } t_state;

    typedef struct packed {
        logic [WORD_W-1:0] hi;
        logic [WORD_W-1:0] lo_even;
        logic [WORD_W-1:0] lo_odd;
    } t_entry;

    typedef struct packed {
        logic             valid;
        logic             is_write;
        logic [VA_W-1:0]  va;
        logic             store;
        logic             hit;
        logic [PFN_W-1:0] pfn;
        logic             d;
        logic             v;
    } t_token;

    typedef struct packed {
        logic [VA_W-1:0] physical_address;
        t_fault          fault;
        logic [VA_W-1:0] bad_address;
    } t_result;

endpackage
`default_nettype wire

[hdl/tlb_req_if.sv]
// Request channel carrying translate and entry write transactions.
`default_nettype none
interface tlb_req_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [31:0] virtual_address;
    logic        is_write_access;
    logic [4:0]  entry_index;
    logic [31:0] new_entry_hi;
    logic [31:0] new_entry_lo_even;
    logic [31:0] new_entry_lo_odd;

    modport source (
        output valid, op, virtual_address, is_write_access, entry_index,
               new_entry_hi, new_entry_lo_even, new_entry_lo_odd,
        input  ready
    );
    modport sink (
        input  valid, op, virtual_address, is_write_access, entry_index,
               new_entry_hi, new_entry_lo_even, new_entry_lo_odd,
        output ready
    );
endinterface
`default_nettype wire

[hdl/tlb_rsp_if.sv]
// Response channel carrying the translation result transactions.
`default_nettype none
interface tlb_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] physical_address;
    logic [1:0]  fault;
    logic [31:0] bad_address;

    modport source (
        output valid, physical_address, fault, bad_address,
        input  ready
    );
    modport sink (
        input  valid, physical_address, fault, bad_address,
        output ready
    );
endinterface
`default_nettype wire

[hdl/tlb_cell.sv]
// One TLB slot with its compare logic and one stage of the lookup chain.
`default_nettype none
module tlb_cell (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_wr_en,
    input  wire tlb_pkg::t_entry             i_wr_entry,
    input  wire logic [tlb_pkg::ASID_W-1:0]  i_asid,
    input  wire tlb_pkg::t_token             i_tok,
    output tlb_pkg::t_token                  o_tok
);
    import tlb_pkg::*;

    t_entry            r_entry;
    t_token            r_tok;
    t_token            n_tok;
    logic              w_global;
    logic              w_match;
    logic [WORD_W-1:0] w_lo;

    assign w_global = r_entry.lo_even[LO_G] & r_entry.lo_odd[LO_G];
    assign w_lo     = i_tok.va[ODD_PAGE_BIT] ? r_entry.lo_odd : r_entry.lo_even;
    assign w_match  = i_tok.valid && !i_tok.is_write && !i_tok.hit
                   && (r_entry.hi[WORD_W-1:PAGE_PAIR_LSB] == i_tok.va[VA_W-1:PAGE_PAIR_LSB])
                   && (w_global || (r_entry.hi[ASID_W-1:0] == i_asid));

    always_comb begin
        n_tok = i_tok;
        if (w_match) begin
            n_tok.hit = 1'b1;
            n_tok.pfn = w_lo[PFN_MSB:PFN_LSB];
            n_tok.d   = w_lo[LO_D];
            n_tok.v   = w_lo[LO_V];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
            r_tok   <= '0;
        end else begin
            if (i_wr_en) begin
                r_entry <= i_wr_entry;
            end
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule
`default_nettype wire

[hdl/tlb_apb.sv]
// Configuration register file holding the current ASID behind an APB port.
`default_nettype none
module tlb_apb (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [tlb_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [tlb_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [tlb_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                 pready,
    output logic [tlb_pkg::ASID_W-1:0]           o_asid
);
    import tlb_pkg::*;

    logic [ASID_W-1:0] r_asid;
    logic              w_wr;

    assign w_wr   = psel && penable && pwrite && (paddr == ADDR_CURRENT_ASID);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_asid <= '0;
        end else if (w_wr) begin
            r_asid <= pwdata[ASID_W-1:0];
        end
    end

    always_comb begin
        unique case (paddr)
            ADDR_CURRENT_ASID: prdata = {{(APB_DATA_W-ASID_W){1'b0}}, r_asid};
            default:           prdata = '0;
        endcase
    end

    assign o_asid = r_asid;

endmodule
`default_nettype wire

[hdl/tlb_address_translation.sv]
// Top level of the fully associative TLB: a chain of slot cells searched by a travelling token.
// Each accepted token passes through every cell register; its result is held pending while the output is stalled.
// One transaction at a time: the next is accepted only once the previous result reaches the output register.
// A finished response waits in the output register while the next transaction is accepted.
// Synchronous active-low reset clears every slot to zero, the ASID register and all control state.
`default_nettype none
module tlb_address_translation #(
    parameter int TLB_ENTRIES = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    tlb_req_if.sink                              i_req,
    tlb_rsp_if.source                            o_rsp,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [tlb_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [tlb_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [tlb_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                 pready
);
    import tlb_pkg::*;

    t_state                  r_state;
    t_state                  n_state;
    t_result                 r_out;
    logic                    r_out_valid;
    t_result                 r_pend;
    t_result                 w_res;
    t_token                  w_chain [TLB_ENTRIES+1];
    logic [TLB_ENTRIES-1:0]  w_chain_valid;
    logic [TLB_ENTRIES-1:0]  w_wr_en;
    logic [ASID_W-1:0]       w_asid;
    t_entry                  w_wr_entry;
    t_token                  w_last;
    logic                    w_accept;
    logic                    w_in_ready;
    logic                    w_can_load;
    logic                    w_load_chain;
    logic                    w_save_pend;
    logic                    w_load_pend;

    tlb_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_asid  (w_asid)
    );

    assign i_req.ready = w_in_ready;
    assign w_accept    = i_req.valid && w_in_ready;

    assign w_wr_entry.hi      = i_req.new_entry_hi;
    assign w_wr_entry.lo_even = i_req.new_entry_lo_even;
    assign w_wr_entry.lo_odd  = i_req.new_entry_lo_odd;

    always_comb begin
        w_chain[0]          = '0;
        w_chain[0].valid    = w_accept;
        w_chain[0].is_write = (i_req.op == OP_WRITE);
        w_chain[0].va       = i_req.virtual_address;
        w_chain[0].store    = i_req.is_write_access;
    end

    for (genvar k = 0; k < TLB_ENTRIES; k++) begin : g_cell
        assign w_wr_en[k] = w_accept && (i_req.op == OP_WRITE)
                         && ({{(32-IDX_W){1'b0}}, i_req.entry_index} == 32'(k));

        tlb_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_wr_en    (w_wr_en[k]),
            .i_wr_entry (w_wr_entry),
            .i_asid     (w_asid),
            .i_tok      (w_chain[k]),
            .o_tok      (w_chain[k+1])
        );

        assign w_chain_valid[k] = w_chain[k+1].valid;
    end

    assign w_last = w_chain[TLB_ENTRIES];

    always_comb begin
        w_res = '0;
        if (!w_last.is_write) begin
            if (!w_last.hit) begin
                w_res.fault       = FAULT_REFILL;
                w_res.bad_address = w_last.va;
            end else if (!w_last.v) begin
                w_res.fault       = FAULT_INVALID;
                w_res.bad_address = w_last.va;
            end else if (w_last.store && !w_last.d) begin
                w_res.fault       = FAULT_MODIFIED;
                w_res.bad_address = w_last.va;
            end else begin
                w_res.physical_address = {w_last.pfn, w_last.va[OFFSET_W-1:0]};
            end
        end
    end

    assign w_can_load = !r_out_valid || o_rsp.ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (w_last.valid) begin
                    n_state = w_can_load ? S_IDLE : S_HOLD;
                end
            end
            S_HOLD: begin
                if (w_can_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_in_ready   = 1'b0;
        w_load_chain = 1'b0;
        w_save_pend  = 1'b0;
        w_load_pend  = 1'b0;
        unique case (r_state)
            S_IDLE: w_in_ready = 1'b1;
            S_RUN: begin
                w_load_chain = w_last.valid && w_can_load;
                w_save_pend  = w_last.valid && !w_can_load;
            end
            S_HOLD: w_load_pend = w_can_load;
            default: w_in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_chain || w_load_pend) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_save_pend) begin
            r_pend <= w_res;
        end
        if (w_load_chain) begin
            r_out <= w_res;
        end else if (w_load_pend) begin
            r_out <= r_pend;
        end
    end

    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.physical_address = r_out.physical_address;
    assign o_rsp.fault            = r_out.fault;
    assign o_rsp.bad_address      = r_out.bad_address;

    a_idle_chain_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (w_chain_valid == '0))
        else $error("Lookup token left in the chain while idle.");

    a_single_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_chain_valid) <= 1)
        else $error("More than one transaction in the lookup chain.");

    a_accept_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_RUN))
        else $error("Accepted transaction did not start a lookup.");

    a_exit_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_last.valid |-> (r_state == S_RUN))
        else $error("Lookup token reached the end of the chain outside a lookup.");

endmodule
`default_nettype wire
